FILE: src/ppe_pkg.sv
package ppe_pkg;

	// Element and arithmetic widths
	localparam int ElemBits = 32;
	localparam int ValW     = 32;
	localparam int FracBits = 16;
	localparam int OpdW     = ValW + 1;
	localparam int ProdW    = 2 * OpdW;
	localparam int SumW     = 64;
	localparam int StrW     = 16;
	localparam int KW       = StrW + 8;
	localparam int QW       = 32;
	localparam int HalfW    = SumW / 2;
	localparam int PartW    = HalfW + KW;
	localparam int NumW     = SumW + KW;
	localparam int RndW     = SumW - FracBits;
	localparam int AddW     = RndW + 2;

	// Operation codes
	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_APPLY = 1'b1;

	// Register indexes
	localparam logic CFG_EDIT_STRENGTH = 1'b0;
	localparam logic CFG_SIGNED_MODE   = 1'b1;

	typedef struct packed {
		logic                   operation;
		logic signed [ValW-1:0] state_value;
		logic signed [ValW-1:0] before_value;
		logic signed [ValW-1:0] after_value;
		logic                   end_of_head;
	} in_item_t;

	typedef struct packed {
		logic signed [ValW-1:0] new_state_value;
		logic                   last_out;
		logic                   head_skipped;
	} out_item_t;

	typedef struct packed {
		logic done;
		logic big;
	} div_stat_t;

	// Sign-extend the low ElemBits of a field to an operand
	function automatic logic signed [OpdW-1:0] elem_sext(input logic [ValW-1:0] x);
		return OpdW'(signed'(x[ElemBits-1:0]));
	endfunction

endpackage

FILE: src/per_head_projection_edit.sv
// Accumulate item: the shared 33x33 multiplier forms state*delta and delta*delta one
// after the other; no new item is taken until the item is done.
// Accumulate item with end of head: two multiplier passes form the numerator, then the
// 88-step restoring divider forms alpha; both are skipped when the delta energy is zero.
// Apply item: product and rounded value registered, then wait for a free output register.
// Reset (arst_n low, asynchronous): sums, alpha and skip clear, strength = 1.0, mode absolute.
module per_head_projection_edit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ppe_pkg::in_item_t           in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ppe_pkg::out_item_t          out_item,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [ppe_pkg::StrW-1:0]    cfg_data
);
	import ppe_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL_SD, S_MUL_DD, S_ACC_DD, S_CHECK, S_MUL_LO, S_MUL_HI,
		S_DIV_START, S_DIV, S_FINISH, S_MUL_AD, S_APPLY_RND, S_APPLY_ADD
	} state_t;

	localparam logic signed [AddW-1:0] ElemMax =
		signed'((AddW'(1) << (ElemBits - 1)) - AddW'(1));
	localparam logic signed [AddW-1:0] ElemMin = -ElemMax - AddW'(1);
	localparam logic [SumW-1:0] RoundHalf = SumW'(1) << (FracBits - 1);
	localparam logic [QW:0] LimPos = (QW+1)'((QW+1)'(1) << (QW - 1)) - (QW+1)'(1);
	localparam logic [QW:0] LimNeg = (QW+1)'(1) << (QW - 1);

	state_t                  state_q;
	logic [StrW-1:0]         strength_q;
	logic                    signed_mode_q;
	logic signed [SumW-1:0]  ssd_q;
	logic [SumW-1:0]         sdd_q;
	logic signed [QW-1:0]    alpha_q;
	logic                    skip_q;
	logic signed [OpdW-1:0]  s_q;
	logic signed [OpdW-1:0]  d_q;
	logic                    last_q;
	logic [PartW-1:0]        p0_q;
	logic                    rnd_neg_q;
	logic [RndW-1:0]         rnd_mag_q;
	logic                    out_valid_q;
	out_item_t               out_item_q;

	logic signed [OpdW-1:0]  mul_a;
	logic signed [OpdW-1:0]  mul_b;
	logic signed [ProdW-1:0] prod;
	logic [SumW-1:0]         mag_a;
	logic [KW-1:0]           k;
	logic signed [SumW:0]    ssd_sum;
	logic signed [SumW-1:0]  ssd_nxt;
	logic [SumW:0]           sdd_sum;
	logic [SumW-1:0]         sdd_nxt;
	logic [SumW-1:0]         p_mag;
	logic [SumW-1:0]         p_rnd;
	logic signed [RndW:0]    v;
	logic signed [AddW-1:0]  n_sum;
	logic signed [AddW-1:0]  n_sat;
	logic                    div_start;
	logic [NumW-1:0]         div_num;
	logic [QW-1:0]           div_quot;
	div_stat_t               div_stat;
	logic                    alpha_neg;
	logic [QW:0]             q_lim;
	logic [QW-1:0]           q_sat;
	logic                    in_xfer;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Magnitude of the state-delta sum and the scaled strength
	always_comb begin
		mag_a = ssd_q[SumW-1] ? (SumW'(0) - unsigned'(ssd_q)) : unsigned'(ssd_q);
		k     = {strength_q, 8'b0};
	end

	// Route operands to the shared multiplier
	always_comb begin
		case (state_q)
			S_MUL_SD: begin
				mul_a = s_q;
				mul_b = d_q;
			end
			S_MUL_DD: begin
				mul_a = d_q;
				mul_b = d_q;
			end
			S_MUL_LO: begin
				mul_a = signed'({1'b0, mag_a[HalfW-1:0]});
				mul_b = signed'({{(OpdW-KW){1'b0}}, k});
			end
			S_MUL_HI: begin
				mul_a = signed'({1'b0, mag_a[SumW-1:HalfW]});
				mul_b = signed'({{(OpdW-KW){1'b0}}, k});
			end
			S_MUL_AD: begin
				mul_a = OpdW'(alpha_q);
				mul_b = d_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ppe_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Saturating accumulation of both sums
	always_comb begin
		ssd_sum = {ssd_q[SumW-1], ssd_q} + {prod[SumW-1], prod[SumW-1:0]};
		if (ssd_sum[SumW] != ssd_sum[SumW-1]) begin
			ssd_nxt = ssd_sum[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
		end else begin
			ssd_nxt = ssd_sum[SumW-1:0];
		end
		sdd_sum = {1'b0, sdd_q} + {1'b0, prod[SumW-1:0]};
		sdd_nxt = sdd_sum[SumW] ? '1 : sdd_sum[SumW-1:0];
	end

	// Round alpha*delta from Q16.16 to an integer, ties away from zero
	always_comb begin
		p_mag = prod[SumW-1] ? (SumW'(0) - prod[SumW-1:0]) : prod[SumW-1:0];
		p_rnd = p_mag + RoundHalf;
	end

	// Add to the state and clamp to the element range
	always_comb begin
		v     = rnd_neg_q ? -signed'({1'b0, rnd_mag_q}) : signed'({1'b0, rnd_mag_q});
		n_sum = AddW'(s_q) + AddW'(v);
		if (n_sum > ElemMax) begin
			n_sat = ElemMax;
		end else if (n_sum < ElemMin) begin
			n_sat = ElemMin;
		end else begin
			n_sat = n_sum;
		end
	end

	// Numerator strength*|sum| from the two partial products
	always_comb begin
		div_start = (state_q == S_DIV_START);
		div_num   = (NumW'(prod[PartW-1:0]) << HalfW) + NumW'(p0_q);
	end

	ppe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (sdd_q),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	// Saturate the quotient and apply the sign
	always_comb begin
		alpha_neg = signed_mode_q && ssd_q[SumW-1];
		q_lim     = alpha_neg ? LimNeg : LimPos;
		if (div_stat.big || ({1'b0, div_quot} > q_lim)) begin
			q_sat = q_lim[QW-1:0];
		end else begin
			q_sat = div_quot;
		end
	end

	// Sequencer, sums, alpha and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			strength_q    <= StrW'(256);
			signed_mode_q <= 1'b0;
			ssd_q         <= '0;
			sdd_q         <= '0;
			alpha_q       <= '0;
			skip_q        <= 1'b0;
			s_q           <= '0;
			d_q           <= '0;
			last_q        <= 1'b0;
			p0_q          <= '0;
			rnd_neg_q     <= 1'b0;
			rnd_mag_q     <= '0;
			out_valid_q   <= 1'b0;
			out_item_q    <= '0;
		end else begin
			// write configuration
			if (cfg_we) begin
				case (cfg_index)
					CFG_EDIT_STRENGTH: strength_q    <= cfg_data;
					CFG_SIGNED_MODE:   signed_mode_q <= cfg_data[0];
					default: ;
				endcase
			end

			// drop the result once transferred, unless a new one replaces it
			if (out_valid_q && out_ready && state_q != S_APPLY_ADD) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						s_q    <= elem_sext(in_item.state_value);
						d_q    <= elem_sext(in_item.after_value)
							- elem_sext(in_item.before_value);
						last_q <= in_item.end_of_head;
						state_q <= (in_item.operation == OP_APPLY) ? S_MUL_AD : S_MUL_SD;
					end
				end
				S_MUL_SD: state_q <= S_MUL_DD;
				S_MUL_DD: begin
					ssd_q   <= ssd_nxt;
					state_q <= S_ACC_DD;
				end
				S_ACC_DD: begin
					sdd_q   <= sdd_nxt;
					state_q <= last_q ? S_CHECK : S_IDLE;
				end
				S_CHECK: begin
					if (sdd_q == '0) begin
						alpha_q <= '0;
						skip_q  <= 1'b1;
						ssd_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MUL_LO;
					end
				end
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: begin
					p0_q    <= prod[PartW-1:0];
					state_q <= S_DIV_START;
				end
				S_DIV_START: state_q <= S_DIV;
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					alpha_q <= alpha_neg ? -signed'(q_sat) : signed'(q_sat);
					skip_q  <= 1'b0;
					ssd_q   <= '0;
					sdd_q   <= '0;
					state_q <= S_IDLE;
				end
				S_MUL_AD: state_q <= S_APPLY_RND;
				S_APPLY_RND: begin
					rnd_neg_q <= prod[SumW-1];
					rnd_mag_q <= p_rnd[SumW-1:FracBits];
					state_q   <= S_APPLY_ADD;
				end
				S_APPLY_ADD: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q                <= 1'b1;
						out_item_q.new_state_value <= ValW'(n_sat);
						out_item_q.last_out        <= last_q;
						out_item_q.head_skipped    <= skip_q;
						state_q                    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: src/ppe_mul.sv
module ppe_mul (
	input  logic                               clk,
	input  logic signed [ppe_pkg::OpdW-1:0]    a,
	input  logic signed [ppe_pkg::OpdW-1:0]    b,
	output logic signed [ppe_pkg::ProdW-1:0]   prod
);
	import ppe_pkg::*;

	// Register the shared product
	always_ff @(posedge clk) begin
		prod <= ProdW'(a) * ProdW'(b);
	end

endmodule

FILE: src/ppe_div.sv
module ppe_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ppe_pkg::NumW-1:0]      num,
	input  logic [ppe_pkg::SumW-1:0]      den,
	output logic [ppe_pkg::QW-1:0]        quot,
	output ppe_pkg::div_stat_t            stat
);
	import ppe_pkg::*;

	localparam int CntW = $clog2(NumW);

	logic            busy_q;
	logic            done_q;
	logic            big_q;
	logic [CntW-1:0] cnt_q;
	logic [NumW-1:0] num_q;
	logic [SumW-1:0] den_q;
	logic [SumW-1:0] rem_q;
	logic [QW-1:0]   quot_q;

	logic [SumW:0]   shifted;
	logic [SumW:0]   diff;
	logic            ge;

	// One restoring step: shift in the next numerator bit, try the subtract
	always_comb begin
		shifted = {rem_q, num_q[NumW-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			big_q  <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			quot_q <= '0;
		end else begin
			// flag the cycle after the last step
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(NumW - 1);
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				quot_q <= '0;
				big_q  <= 1'b0;
			end else if (busy_q) begin
				rem_q <= ge ? diff[SumW-1:0] : shifted[SumW-1:0];
				num_q <= num_q << 1;
				// freeze the quotient once it no longer fits
				if (!big_q) begin
					if (quot_q[QW-1]) begin
						big_q <= 1'b1;
					end else begin
						quot_q <= {quot_q[QW-2:0], ge};
					end
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign quot      = quot_q;
	assign stat.done = done_q;
	assign stat.big  = big_q;

endmodule
